// ----- src/tama_pkg.sv -----
// ----------------------------------------------------------------------------
// tama_pkg
// Shared types and constants of the three-address memory ALU: instruction
// action codes, status codes, state encodings and the request and response
// structures between the controller and the execution unit.
// ----------------------------------------------------------------------------
package tama_pkg;

  localparam int WORD_W        = 32;
  localparam int PRELOAD_WORDS = 5;

  typedef enum logic [2:0] {
    ACT_ADD,
    ACT_SUB,
    ACT_MUL,
    ACT_DIV,
    ACT_MOD,
    ACT_POW,
    ACT_STORE,
    ACT_READ
  } action_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ERR,
    ST_OVF
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDA,
    S_RDB,
    S_CAPB,
    S_RUN,
    S_WB
  } ctl_state_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_MUL,
    EX_DIV,
    EX_DIVFIN,
    EX_POW,
    EX_FIN
  } ex_state_t;

  typedef struct packed {
    logic    start;
    action_t action;
  } ex_req_t;

  typedef struct packed {
    logic              done;
    logic              write;
    status_t           status;
    logic [WORD_W-1:0] value;
  } ex_rsp_t;

  function automatic logic [WORD_W-1:0] preload_word(input logic [2:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      3'd0:    w = 32'd4;
      3'd1:    w = 32'd23;
      3'd2:    w = 32'd10;
      3'd3:    w = 32'd40;
      3'd4:    w = 32'd5;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- src/tama_ram.sv -----
// ----------------------------------------------------------------------------
// tama_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ----------------------------------------------------------------------------
module tama_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tama_exec.sv -----
// ----------------------------------------------------------------------------
// tama_exec
// Execution unit. Add, subtract, store and read finish at once; multiply
// takes a registered product and an overflow check; divide and remainder
// use a one-bit-per-cycle restoring divider on magnitudes; power runs
// square and multiply alongside an exact magnitude check for overflow.
// ----------------------------------------------------------------------------
module tama_exec (
  input  logic                           clk,
  input  logic                           rst,
  input  tama_pkg::ex_req_t              req,
  input  logic [tama_pkg::WORD_W-1:0]    op_a,
  input  logic [tama_pkg::WORD_W-1:0]    op_b,
  input  logic [tama_pkg::WORD_W-1:0]    store_value,
  output tama_pkg::ex_rsp_t              rsp
);
  import tama_pkg::*;

  ex_state_t state, state_next;

  action_t            op;
  logic [WORD_W-1:0]  res;
  status_t            st;
  logic               wr;

  logic signed [63:0] prod;
  logic signed [63:0] prod_c;

  logic [WORD_W-1:0]  dq;
  logic [WORD_W-1:0]  div_d;
  logic [WORD_W-1:0]  rem;
  logic [4:0]         cnt;
  logic               neg_q;
  logic               neg_r;

  logic [WORD_W-1:0]  acc;
  logic [WORD_W-1:0]  base;
  logic [30:0]        n;
  logic [WORD_W-1:0]  mag;
  logic [WORD_W-1:0]  amag;
  logic [4:0]         k;
  logic               over;
  logic               p_small;
  logic               p_bige;
  logic               p_neg;

  logic               a_neg;
  logic               b_neg;
  logic [WORD_W-1:0]  a_mag;
  logic [WORD_W-1:0]  b_mag;
  logic [WORD_W:0]    sum;
  logic [WORD_W:0]    diff;
  logic [WORD_W:0]    shifted;
  logic [WORD_W:0]    trial;
  logic               ge;
  logic [WORD_W-1:0]  rem_next;
  logic [WORD_W-1:0]  acc_mul;
  logic [WORD_W-1:0]  base_sq;
  logic [63:0]        mprod;
  logic               mag_big;
  logic               pow_done;

  assign a_neg    = op_a[WORD_W-1];
  assign b_neg    = op_b[WORD_W-1];
  assign a_mag    = a_neg ? -op_a : op_a;
  assign b_mag    = b_neg ? -op_b : op_b;
  assign sum      = {op_a[WORD_W-1], op_a} + {op_b[WORD_W-1], op_b};
  assign diff     = {op_a[WORD_W-1], op_a} - {op_b[WORD_W-1], op_b};
  assign prod_c   = 64'($signed(op_a)) * 64'($signed(op_b));

  assign shifted  = {rem, dq[WORD_W-1]};
  assign trial    = shifted - {1'b0, div_d};
  assign ge       = !trial[WORD_W];
  assign rem_next = ge ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];

  assign acc_mul  = acc * base;
  assign base_sq  = base * base;
  assign mprod    = 64'(mag) * 64'(amag);
  assign mag_big  = mprod > 64'h0000_0000_8000_0000;
  assign pow_done = (n == '0) && ((k == '0) || over);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      EX_IDLE: begin
        if (req.start) begin
          unique case (req.action) inside
            ACT_MUL: begin
              state_next = EX_MUL;
            end
            ACT_DIV, ACT_MOD: begin
              state_next = (op_b == '0) ? EX_FIN : EX_DIV;
            end
            ACT_POW: begin
              state_next = (!b_neg && (op_b != '0)) ? EX_POW : EX_FIN;
            end
            default: begin
              state_next = EX_FIN;
            end
          endcase
        end
      end
      EX_MUL: begin
        state_next = EX_FIN;
      end
      EX_DIV: begin
        if (cnt == 5'd31) begin
          state_next = EX_DIVFIN;
        end
      end
      EX_DIVFIN: begin
        state_next = EX_FIN;
      end
      EX_POW: begin
        if (pow_done) begin
          state_next = EX_FIN;
        end
      end
      EX_FIN: begin
        state_next = EX_IDLE;
      end
      default: begin
        state_next = EX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      EX_IDLE: begin
        if (req.start) begin
          op <= req.action;
          st <= ST_OK;
          wr <= 1'b1;
          case (req.action) inside
            ACT_ADD: begin
              res <= sum[WORD_W-1:0];
              st  <= (sum[WORD_W] ^ sum[WORD_W-1]) ? ST_OVF : ST_OK;
            end
            ACT_SUB: begin
              res <= diff[WORD_W-1:0];
              st  <= (diff[WORD_W] ^ diff[WORD_W-1]) ? ST_OVF : ST_OK;
            end
            ACT_MUL: begin
              prod <= prod_c;
            end
            ACT_DIV, ACT_MOD: begin
              if (op_b == '0) begin
                res <= '0;
                st  <= ST_ERR;
                wr  <= 1'b0;
              end
              dq    <= a_mag;
              div_d <= b_mag;
              rem   <= '0;
              cnt   <= '0;
              neg_q <= a_neg ^ b_neg;
              neg_r <= a_neg;
            end
            ACT_POW: begin
              if (op_b == '0) begin
                res <= 32'd1;
              end else if (b_neg) begin
                if (op_a == '0) begin
                  res <= '0;
                  st  <= ST_ERR;
                  wr  <= 1'b0;
                end else if (op_a == 32'd1) begin
                  res <= 32'd1;
                end else if (op_a == 32'hFFFF_FFFF) begin
                  res <= op_b[0] ? 32'hFFFF_FFFF : 32'd1;
                end else begin
                  res <= '0;
                end
              end
              acc     <= 32'd1;
              base    <= op_a;
              n       <= op_b[30:0];
              amag    <= a_mag;
              mag     <= 32'd1;
              over    <= 1'b0;
              p_small <= a_mag <= 32'd1;
              p_bige  <= |op_b[30:5];
              p_neg   <= a_neg & op_b[0];
              k       <= ((a_mag <= 32'd1) || (|op_b[30:5])) ? 5'd0 : op_b[4:0];
            end
            ACT_STORE: begin
              res <= store_value;
            end
            default: begin
              res <= op_a;
              wr  <= 1'b0;
            end
          endcase
        end
      end
      EX_MUL: begin
        res <= prod[WORD_W-1:0];
        st  <= ((&prod[63:31]) || !(|prod[63:31])) ? ST_OK : ST_OVF;
      end
      EX_DIV: begin
        rem <= rem_next;
        dq  <= {dq[WORD_W-2:0], ge};
        cnt <= cnt + 5'd1;
      end
      EX_DIVFIN: begin
        if (op == ACT_DIV) begin
          res <= neg_q ? -dq : dq;
          st  <= (dq[WORD_W-1] && !neg_q) ? ST_OVF : ST_OK;
        end else begin
          res <= neg_r ? -rem : rem;
          st  <= ST_OK;
        end
      end
      EX_POW: begin
        if (n != '0) begin
          if (n[0]) begin
            acc <= acc_mul;
          end
          base <= base_sq;
          n    <= n >> 1;
        end
        if ((k != '0) && !over) begin
          if (mag_big) begin
            over <= 1'b1;
          end else begin
            mag <= mprod[WORD_W-1:0];
          end
          k <= k - 5'd1;
        end
        if (pow_done) begin
          res <= acc;
          if (p_small) begin
            st <= ST_OK;
          end else if (p_bige || over) begin
            st <= ST_OVF;
          end else if (p_neg) begin
            st <= ST_OK;
          end else begin
            st <= mag[WORD_W-1] ? ST_OVF : ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.done   = (state == EX_FIN);
  assign rsp.write  = wr;
  assign rsp.status = st;
  assign rsp.value  = res;

  assert property (@(posedge clk) disable iff (rst) req.start |-> state == EX_IDLE)
    else $error("Execution unit started while busy.");

  assert property (@(posedge clk) disable iff (rst) state == EX_DIV |-> div_d != '0)
    else $error("Divider running with a zero divisor.");

  assert property (@(posedge clk) disable iff (rst)
      (state == EX_POW && pow_done && !p_small && !p_bige && !over) |-> mag <= 32'h8000_0000)
    else $error("Power magnitude check passed its bound.");

endmodule

// ----- src/three_address_memory_alu.sv -----
// ----------------------------------------------------------------------------
// three_address_memory_alu
// Executes one three-address instruction per input word against a data
// memory of MEM_WORDS signed 32-bit words.
//
// Input channel: in_valid / in_stall with action, dest_index, first_index,
// second_index and store_value. Output channel: out_valid / out_stall with
// result_value and status. A word moves on a channel at a clock edge where
// valid is high and stall is low. Each instruction gives one output word.
// After reset the controller runs a clearing pass over the whole memory that
// loads 4, 23, 10, 40, 5 into words 0 to 4 and zero elsewhere; in_stall is
// high during that pass. One instruction is in flight at a time: two operand
// reads on the single memory read port, the execution unit, then write-back.
// Multiply goes through a registered product, divide and remainder through
// the one-bit divider and power through the square-and-multiply loop. The
// next instruction is taken the cycle after write-back. The output register
// holds a finished word while out_stall is high; a following instruction
// then waits at write-back.
// ----------------------------------------------------------------------------
module three_address_memory_alu #(
  parameter int MEM_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [7:0]  dest_index,
  input  logic [7:0]  first_index,
  input  logic [7:0]  second_index,
  input  logic [31:0] store_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value,
  output logic [1:0]  status
);
  import tama_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  ctl_state_t state, state_next;

  logic [AW-1:0]     clr_addr;
  logic              clr_last;
  logic [WORD_W-1:0] clr_word;

  action_t           act_q;
  logic [7:0]        dest_q;
  logic [7:0]        first_q;
  logic [7:0]        second_q;
  logic [WORD_W-1:0] store_q;
  logic [WORD_W-1:0] a_q;
  logic              rd_ok;

  logic [7:0]        a_idx;
  logic              a_ok;
  logic              b_ok;
  logic              dest_ok;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  ex_req_t           ex_req;
  ex_rsp_t           ex_rsp;
  logic [WORD_W-1:0] op_b;

  logic              out_free;
  logic              load_out;

  assign a_idx    = (act_q == ACT_READ) ? dest_q : first_q;
  assign a_ok     = 32'(a_idx) < 32'(MEM_WORDS);
  assign b_ok     = 32'(second_q) < 32'(MEM_WORDS);
  assign dest_ok  = 32'(dest_q) < 32'(MEM_WORDS);
  assign clr_last = clr_addr == AW'(MEM_WORDS - 1);
  assign clr_word = (32'(clr_addr) < 32'(PRELOAD_WORDS)) ? preload_word(clr_addr[2:0]) : '0;
  assign op_b     = rd_ok ? ram_rdata : '0;
  assign out_free = !out_valid || !out_stall;

  tama_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tama_exec u_exec (
    .clk         (clk),
    .rst         (rst),
    .req         (ex_req),
    .op_a        (a_q),
    .op_b        (op_b),
    .store_value (store_q),
    .rsp         (ex_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = AW'(dest_q);
    ram_wdata     = ex_rsp.value;
    ram_raddr     = AW'(a_idx);
    ex_req.start  = 1'b0;
    ex_req.action = act_q;
    load_out      = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = clr_word;
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_RDA;
        end
      end
      S_RDA: begin
        ram_raddr  = AW'(a_idx);
        state_next = S_RDB;
      end
      S_RDB: begin
        ram_raddr  = AW'(second_q);
        state_next = S_CAPB;
      end
      S_CAPB: begin
        ex_req.start = 1'b1;
        state_next   = S_RUN;
      end
      S_RUN: begin
        if (ex_rsp.done) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        if (out_free) begin
          ram_we     = ex_rsp.write && dest_ok;
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act_q    <= action_t'(action);
      dest_q   <= dest_index;
      first_q  <= first_index;
      second_q <= second_index;
      store_q  <= store_value;
    end
    if (state == S_RDA) begin
      rd_ok <= a_ok;
    end
    if (state == S_RDB) begin
      a_q   <= rd_ok ? ram_rdata : '0;
      rd_ok <= b_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_value <= ex_rsp.value;
      status       <= ex_rsp.status;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      (state == S_WB && ram_we) |-> ex_rsp.status != ST_ERR)
    else $error("Memory written by an instruction that ended in error.");

  assert property (@(posedge clk) disable iff (rst) ex_rsp.done |-> state == S_RUN)
    else $error("Execution result arrived while the controller was not waiting.");

  assert property (@(posedge clk) disable iff (rst)
      (state == S_WB && (act_q == ACT_STORE || act_q == ACT_READ)) |-> ex_rsp.status == ST_OK)
    else $error("Store or read word reported a nonzero status.");

  assert property (@(posedge clk) disable iff (rst)
      (state == S_WB && act_q == ACT_READ) |-> !ex_rsp.write)
    else $error("Read word marked for write-back.");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the three-address memory ALU against its own copy of the data
// memory. Each accepted instruction word is executed on the copy, and every
// output word is compared, value and status, with the oldest prediction.
// A short directed sequence covers wrap, overflow, division by zero and the
// power corner cases. Random instructions on a small working set of words
// follow, under three patterns of idling on both channels, the last with none.
// ----------------------------------------------------------------------------
module tb_top;
  import tama_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 50;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -(64'sd2147483648);

  class alu_scoreboard;
    logic [31:0] mem_words [0:255];
    logic [31:0] want_value [$];
    status_t want_status [$];
    int mismatches;

    function new();
      foreach (mem_words[i]) mem_words[i] = '0;
      mem_words[0] = 32'd4;
      mem_words[1] = 32'd23;
      mem_words[2] = 32'd10;
      mem_words[3] = 32'd40;
      mem_words[4] = 32'd5;
      mismatches = 0;
    endfunction

    function bit overflows(longint v);
      return v > WORD_MAX || v < WORD_MIN;
    endfunction

    function status_t power_word(logic [31:0] base_w, logic [31:0] exp_w,
                                 output logic [31:0] res);
      int base_i;
      int exp_i;
      longint b;
      longint e;
      longint amag;
      longint mag;
      logic [31:0] acc;
      logic [31:0] sq;
      logic [31:0] n;
      base_i = base_w;
      exp_i = exp_w;
      b = base_i;
      e = exp_i;
      res = 32'd1;
      if (e == 0) return ST_OK;
      if (e < 0) begin
        if (b == 0) begin
          res = '0;
          return ST_ERR;
        end
        if (b == 1) return ST_OK;
        if (b == -1) begin
          res = exp_w[0] ? 32'hFFFF_FFFF : 32'd1;
          return ST_OK;
        end
        res = '0;
        return ST_OK;
      end
      acc = 32'd1;
      sq = base_w;
      n = exp_w;
      while (n != 0) begin
        if (n[0]) acc = acc * sq;
        sq = sq * sq;
        n = n >> 1;
      end
      res = acc;
      amag = (b < 0) ? -b : b;
      if (amag <= 1) return ST_OK;
      if (e >= 32) return ST_OVF;
      mag = 1;
      for (longint k = 0; k < e; k++) begin
        mag = mag * amag;
        if (mag > 64'sh8000_0000) return ST_OVF;
      end
      if (b < 0 && exp_w[0]) return (mag > 64'sh8000_0000) ? ST_OVF : ST_OK;
      return (mag > 64'sh7FFF_FFFF) ? ST_OVF : ST_OK;
    endfunction

    function void note_instr(action_t act, logic [7:0] di, logic [7:0] fi,
                             logic [7:0] si, logic [31:0] sv);
      logic [31:0] a_w;
      logic [31:0] b_w;
      logic [31:0] res;
      int a_i;
      int b_i;
      longint a;
      longint b;
      longint wide;
      status_t st;
      bit wr;
      a_w = mem_words[fi];
      b_w = mem_words[si];
      a_i = a_w;
      b_i = b_w;
      a = a_i;
      b = b_i;
      res = '0;
      st = ST_OK;
      wr = 1'b1;
      case (act)
        ACT_ADD, ACT_SUB, ACT_MUL: begin
          if (act == ACT_ADD) wide = a + b;
          else if (act == ACT_SUB) wide = a - b;
          else wide = a * b;
          res = wide[31:0];
          if (overflows(wide)) st = ST_OVF;
        end
        ACT_DIV, ACT_MOD: begin
          if (b == 0) begin
            st = ST_ERR;
            wr = 1'b0;
          end else begin
            wide = (act == ACT_DIV) ? a / b : a % b;
            res = wide[31:0];
            if (overflows(wide)) st = ST_OVF;
          end
        end
        ACT_POW: begin
          st = power_word(a_w, b_w, res);
          if (st == ST_ERR) begin
            wr = 1'b0;
            res = '0;
          end
        end
        ACT_STORE: res = sv;
        default: begin
          res = mem_words[di];
          wr = 1'b0;
        end
      endcase
      if (wr) mem_words[di] = res;
      want_value.push_back(res);
      want_status.push_back(st);
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] st);
      logic [31:0] ev;
      status_t es;
      if (want_value.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: value %h status %0d", value, st);
        return;
      end
      ev = want_value.pop_front();
      es = want_status.pop_front();
      if (value !== ev || st !== es) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %h status %0d, got value %h status %0d",
                   ev, es, value, st);
      end
    endfunction

    function int pending();
      return want_value.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  action;
  logic [7:0]  dest_index;
  logic [7:0]  first_index;
  logic [7:0]  second_index;
  logic [31:0] store_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] result_value;
  logic [1:0]  status;

  alu_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  three_address_memory_alu uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .dest_index   (dest_index),
    .first_index  (first_index),
    .second_index (second_index),
    .store_value  (store_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] pick_index();
    if ($urandom_range(99) < 80) return 8'($urandom_range(15));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(5))
      0, 1: v = $urandom_range(16) - 8;
      2: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      3: v = $urandom_range(80) - 40;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_instr(input action_t act, input logic [7:0] di,
                            input logic [7:0] fi, input logic [7:0] si,
                            input logic [31:0] sv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    dest_index <= di;
    first_index <= fi;
    second_index <= si;
    store_value <= sv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_instr(act, di, fi, si, sv);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    int pick;
    action_t act;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 25) act = ACT_STORE;
      else if (pick < 30) act = ACT_READ;
      else act = action_t'($urandom_range(ACT_POW));
      send_instr(act, pick_index(), pick_index(), pick_index(), pick_value());
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(result_value, status);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("three_address_memory_alu test failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ACT_ADD;
    dest_index <= '0;
    first_index <= '0;
    second_index <= '0;
    store_value <= '0;
    out_stall <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 24;
    recv_idle_pct = 75;
    send_instr(ACT_READ, 8'd4, 8'd0, 8'd0, 32'd0);
    send_instr(ACT_ADD, 8'd5, 8'd1, 8'd3, 32'd0);
    send_instr(ACT_STORE, 8'd10, 8'd0, 8'd0, 32'h7FFF_FFFF);
    send_instr(ACT_STORE, 8'd11, 8'd0, 8'd0, 32'h8000_0000);
    send_instr(ACT_STORE, 8'd12, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_instr(ACT_STORE, 8'd14, 8'd0, 8'd0, 32'd1);
    send_instr(ACT_ADD, 8'd20, 8'd10, 8'd10, 32'd0);
    send_instr(ACT_SUB, 8'd21, 8'd11, 8'd14, 32'd0);
    send_instr(ACT_MUL, 8'd22, 8'd11, 8'd11, 32'd0);
    send_instr(ACT_DIV, 8'd23, 8'd11, 8'd12, 32'd0);
    send_instr(ACT_MOD, 8'd24, 8'd11, 8'd12, 32'd0);
    send_instr(ACT_DIV, 8'd25, 8'd1, 8'd13, 32'd0);
    send_instr(ACT_MOD, 8'd26, 8'd3, 8'd13, 32'd0);
    send_instr(ACT_READ, 8'd25, 8'd0, 8'd0, 32'd0);
    send_instr(ACT_POW, 8'd27, 8'd13, 8'd13, 32'd0);
    send_instr(ACT_POW, 8'd28, 8'd13, 8'd12, 32'd0);
    send_instr(ACT_POW, 8'd29, 8'd12, 8'd12, 32'd0);
    send_instr(ACT_POW, 8'd30, 8'd14, 8'd12, 32'd0);
    send_instr(ACT_POW, 8'd31, 8'd0, 8'd12, 32'd0);
    send_instr(ACT_STORE, 8'd15, 8'd0, 8'd0, 32'd31);
    send_instr(ACT_STORE, 8'd17, 8'd0, 8'd0, 32'hFFFF_FFFE);
    send_instr(ACT_POW, 8'd33, 8'd17, 8'd15, 32'd0);
    send_instr(ACT_POW, 8'd34, 8'd4, 8'd15, 32'd0);
    send_instr(ACT_POW, 8'd35, 8'd17, 8'd10, 32'd0);
    send_instr(ACT_STORE, 8'd255, 8'd0, 8'd0, 32'hA5A5_A5A5);
    send_instr(ACT_READ, 8'd255, 8'd255, 8'd255, 32'd0);

    run_phase(24, 75, 150);
    run_phase(75, 24, 150);
    run_phase(0, 0, 150);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("three_address_memory_alu test passed");
    end else begin
      $display("three_address_memory_alu test failed");
    end
    $finish;
  end

endmodule
